FILE: rtl/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg: shared types and constants for the RGB to HSV converter
// Holds the pipeline depth, the divider lane layout and the restoring
// division step used by the hue and saturation dividers.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

   // Pixel channel width
   localparam int unsigned CHAN_W = 8;

   // Divider geometry: 17-bit dividend, 9-bit divisor, 8-bit quotient
   localparam int unsigned NUM_W  = 17;
   localparam int unsigned DEN_W  = 9;
   localparam int unsigned QUO_W  = 8;

   // Hue magnitude before scaling: at most five times delta
   localparam int unsigned HMAG_W = 11;

   // Pipeline layout: three front stages, the divider stages, one output stage
   localparam int unsigned FRONT_STAGES   = 3;
   localparam int unsigned DIV_BITS_STAGE = 2;
   localparam int unsigned DIV_STAGES     = QUO_W / DIV_BITS_STAGE;
   localparam int unsigned PIPE_DEPTH     = FRONT_STAGES + DIV_STAGES + 1;

   // Hue scale factor (hue = 85 * sum / (2 * delta)) and saturation scale
   localparam int unsigned HUE_SCALE = 85;
   localparam int unsigned SAT_SCALE = 255;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [NUM_W-1:0]  div_num_type;
   typedef logic [DEN_W-1:0]  div_den_type;
   typedef logic [QUO_W-1:0]  div_quo_type;

   // Sector of the largest channel; ties resolve red, then green, then blue
   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   // One divider in flight: partial remainder, divisor, quotient so far
   typedef struct packed {
      div_num_type rem;
      div_den_type den;
      div_quo_type quo;
   } div_lane_type;

   // Side information that rides along with the dividers
   typedef struct packed {
      logic     gray;
      logic     black;
      logic     neg;
      chan_type brightness;
   } pix_tag_type;

   // One restoring division step at the given quotient bit position
   function automatic div_lane_type div_step(div_lane_type lane, int unsigned shift);
      div_num_type  trial;
      div_lane_type res;
      trial   = div_num_type'(lane.den) << shift;
      res     = lane;
      res.quo = {lane.quo[QUO_W-2:0], 1'b0};
      if (lane.rem >= trial) begin
         res.rem    = lane.rem - trial;
         res.quo[0] = 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb_to_hsv_8bit.sv
// Path: a pixel passes eight register stages, the first loaded at its input
//   transfer edge, before its result is offered on the rsp_ side.
// Throughput: one pixel per cycle while the rsp_ side accepts; the two 8-bit
//   dividers resolve two quotient bits per stage over four stages, which sets the depth.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// Reset (synchronous, active high) empties the pipeline; data is not cleared.
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit: pipelined 8-bit RGB to HSV converter
// Finds max and min, forms hue and saturation numerators, divides them in a
// pipelined restoring divider pair and applies the gray and black cases.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_8bit
   import rhsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_hue,
   output logic [7:0]      rsp_saturation,
   output logic [7:0]      rsp_brightness
);

   localparam int unsigned OUT_STAGE = PIPE_DEPTH - 1;

   // Pipeline control
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] adv;

   // Stage 0: max, min, sector and channel difference
   chan_type          s0_max_ff, s0_min_ff;
   sector_type        s0_sector_ff;
   logic signed [8:0] s0_diff_ff;

   chan_type          s0_max_in, s0_min_in;
   chan_type          rg_max, rg_min;
   sector_type        s0_sector_in;
   logic signed [8:0] s0_diff_in;

   // Stage 1: delta and hue magnitude with its sign
   chan_type           s1_delta_ff, s1_max_ff;
   logic [HMAG_W-1:0]  s1_hmag_ff;
   logic               s1_neg_ff;

   chan_type           s1_delta_in;
   logic signed [11:0] hsum;
   logic [11:0]        hsum_abs;

   // Stage 2: divider operands
   div_lane_type s2_hue_ff, s2_sat_ff;
   pix_tag_type  s2_tag_ff;

   div_lane_type s2_hue_in, s2_sat_in;
   pix_tag_type  s2_tag_in;

   // Divider stages
   div_lane_type hdiv_ff [DIV_STAGES];
   div_lane_type sdiv_ff [DIV_STAGES];
   pix_tag_type  dtag_ff [DIV_STAGES];

   // Output stage
   logic [7:0] rsp_hue_ff, rsp_saturation_ff, rsp_brightness_ff;
   logic [7:0] rsp_hue_in, rsp_saturation_in;
   div_quo_type hue_quo;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[OUT_STAGE] = !valid_ff[OUT_STAGE] || rsp_ready;
      for (int i = OUT_STAGE - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[OUT_STAGE];

   // Move valid bits along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Stage 0: find the largest channel, its sector and the opposing difference
   always_comb begin
      rg_max    = (req_red >= req_green) ? req_red : req_green;
      rg_min    = (req_red <= req_green) ? req_red : req_green;
      s0_max_in = (rg_max >= req_blue) ? rg_max : req_blue;
      s0_min_in = (rg_min <= req_blue) ? rg_min : req_blue;
      if (s0_max_in == req_red) begin
         s0_sector_in = SECTOR_RED;
         s0_diff_in   = $signed({1'b0, req_green}) - $signed({1'b0, req_blue});
      end else if (s0_max_in == req_green) begin
         s0_sector_in = SECTOR_GREEN;
         s0_diff_in   = $signed({1'b0, req_blue}) - $signed({1'b0, req_red});
      end else begin
         s0_sector_in = SECTOR_BLUE;
         s0_diff_in   = $signed({1'b0, req_red}) - $signed({1'b0, req_green});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_max_ff    <= s0_max_in;
         s0_min_ff    <= s0_min_in;
         s0_sector_ff <= s0_sector_in;
         s0_diff_ff   <= s0_diff_in;
      end
   end

   // Stage 1: add the sector offset (2k * delta) and split off the sign
   always_comb begin
      s1_delta_in = s0_max_ff - s0_min_ff;
      case (s0_sector_ff)
         SECTOR_RED:   hsum = {{3{s0_diff_ff[8]}}, s0_diff_ff};
         SECTOR_GREEN: hsum = $signed({3'b000, s1_delta_in, 1'b0})
                              + $signed({{3{s0_diff_ff[8]}}, s0_diff_ff});
         SECTOR_BLUE:  hsum = $signed({2'b00, s1_delta_in, 2'b00})
                              + $signed({{3{s0_diff_ff[8]}}, s0_diff_ff});
         default:      hsum = '0;
      endcase
      hsum_abs = hsum[11] ? 12'(-hsum) : 12'(hsum);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_delta_ff <= s1_delta_in;
         s1_max_ff   <= s0_max_ff;
         s1_hmag_ff  <= hsum_abs[HMAG_W-1:0];
         s1_neg_ff   <= hsum[11];
      end
   end

   // Stage 2: scale numerators and set up both dividers
   always_comb begin
      s2_hue_in.rem = NUM_W'(s1_hmag_ff) * NUM_W'(HUE_SCALE);
      s2_hue_in.den = {s1_delta_ff, 1'b0};
      s2_hue_in.quo = '0;
      s2_sat_in.rem = NUM_W'(s1_delta_ff) * NUM_W'(SAT_SCALE);
      s2_sat_in.den = DEN_W'(s1_max_ff);
      s2_sat_in.quo = '0;
      s2_tag_in.gray       = (s1_delta_ff == '0);
      s2_tag_in.black      = (s1_max_ff == '0);
      s2_tag_in.neg        = s1_neg_ff;
      s2_tag_in.brightness = s1_max_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_hue_ff <= s2_hue_in;
         s2_sat_ff <= s2_sat_in;
         s2_tag_ff <= s2_tag_in;
      end
   end

   // Divider stages: resolve two quotient bits per stage, most significant first
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      div_lane_type hue_src, sat_src;
      pix_tag_type  tag_src;
      div_lane_type hue_in, sat_in;

      if (j == 0) begin : g_first
         assign hue_src = s2_hue_ff;
         assign sat_src = s2_sat_ff;
         assign tag_src = s2_tag_ff;
      end else begin : g_next
         assign hue_src = hdiv_ff[j-1];
         assign sat_src = sdiv_ff[j-1];
         assign tag_src = dtag_ff[j-1];
      end

      always_comb begin
         hue_in = hue_src;
         sat_in = sat_src;
         for (int t = 0; t < DIV_BITS_STAGE; t++) begin
            hue_in = div_step(hue_in, QUO_W - 1 - (j * DIV_BITS_STAGE + t));
            sat_in = div_step(sat_in, QUO_W - 1 - (j * DIV_BITS_STAGE + t));
         end
      end

      always_ff @(posedge clock) begin
         if (adv[FRONT_STAGES + j]) begin
            hdiv_ff[j] <= hue_in;
            sdiv_ff[j] <= sat_in;
            dtag_ff[j] <= tag_src;
         end
      end
   end

   // Output stage: apply sign and the gray and black cases
   always_comb begin
      hue_quo = hdiv_ff[DIV_STAGES-1].quo;
      if (dtag_ff[DIV_STAGES-1].gray) begin
         rsp_hue_in = '0;
      end else if (dtag_ff[DIV_STAGES-1].neg) begin
         rsp_hue_in = 8'(-hue_quo);
      end else begin
         rsp_hue_in = hue_quo;
      end
      rsp_saturation_in = dtag_ff[DIV_STAGES-1].black ? '0 : sdiv_ff[DIV_STAGES-1].quo;
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STAGE]) begin
         rsp_hue_ff        <= rsp_hue_in;
         rsp_saturation_ff <= rsp_saturation_in;
         rsp_brightness_ff <= dtag_ff[DIV_STAGES-1].brightness;
      end
   end

   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_saturation_ff;
   assign rsp_brightness = rsp_brightness_ff;

endmodule

`default_nettype wire

FILE: tb/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker: result predictor and comparator for rgb_to_hsv_8bit
// Watches both channels. Each pixel transfer is converted to its expected
// hue, saturation and brightness and held in order. Each result transfer is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module hsv_checker
   import rhsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_hue,
   input  logic [7:0]  rsp_saturation,
   input  logic [7:0]  rsp_brightness,
   output int          mismatch_count,
   output int          outstanding,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HUE_MUL = 85;
   localparam int SAT_MUL = 255;

   typedef struct {
      chan_type hue;
      chan_type saturation;
      chan_type brightness;
   } hsv_pixel_type;

   hsv_pixel_type hsv_expected_q[$];

   // Convert one pixel with exact integer arithmetic
   function automatic hsv_pixel_type rgb_to_hsv_predict(chan_type r, chan_type g, chan_type b);
      hsv_pixel_type res;
      sector_type sector;
      int rv, gv, bv, mx, mn, d, diff, k, num;
      rv = int'(r);
      gv = int'(g);
      bv = int'(b);
      mx = rv;
      mn = rv;
      if (gv > mx) mx = gv;
      if (bv > mx) mx = bv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      d = mx - mn;
      res.brightness = chan_type'(mx);
      res.saturation = (mx == 0) ? '0 : chan_type'((SAT_MUL * d) / mx);
      if (d == 0) begin
         res.hue = '0;
      end else begin
         // ties go red first, then green
         if (mx == rv) sector = SECTOR_RED;
         else if (mx == gv) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED:   diff = gv - bv;
            SECTOR_GREEN: diff = bv - rv;
            default:      diff = rv - gv;
         endcase
         k = int'(sector);
         // signed division truncates toward zero; negative red hue wraps
         num = HUE_MUL * (2 * k * d + diff);
         res.hue = chan_type'(num / (2 * d));
      end
      return res;
   endfunction

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   always @(posedge clock) begin
      hsv_pixel_type want;
      if (!reset) begin
         // retire the oldest expectation against each result transfer
         if (rsp_valid && rsp_ready) begin
            if (hsv_expected_q.size() == 0) begin
               $error("result transfer with no pixel outstanding: hue %0d sat %0d val %0d",
                      rsp_hue, rsp_saturation, rsp_brightness);
               mismatch_count++;
            end else begin
               want = hsv_expected_q.pop_front();
               results_checked++;
               if (rsp_hue !== want.hue) begin
                  $error("hue mismatch: expected %0d, actual %0d", want.hue, rsp_hue);
                  mismatch_count++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $error("saturation mismatch: expected %0d, actual %0d",
                         want.saturation, rsp_saturation);
                  mismatch_count++;
               end
               if (rsp_brightness !== want.brightness) begin
                  $error("brightness mismatch: expected %0d, actual %0d",
                         want.brightness, rsp_brightness);
                  mismatch_count++;
               end
            end
         end
         // predict each pixel transfer
         if (req_valid && req_ready)
            hsv_expected_q.push_back(rgb_to_hsv_predict(req_red, req_green, req_blue));
      end
      outstanding = hsv_expected_q.size();
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for rgb_to_hsv_8bit
// Sends directed corner pixels then a random mix of plain, gray, tied,
// near-gray and extreme pixels in bursts, while the result side stalls on
// its own pattern and once holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rhsv_pkg::*;

   localparam int RANDOM_PIXELS = 1250;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 120;
   localparam int HOLD_AT       = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_red = '0;
   logic [7:0] req_green = '0;
   logic [7:0] req_blue = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_hue;
   logic [7:0] rsp_saturation;
   logic [7:0] rsp_brightness;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int pixels_sent = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   bit hold_off_go   = 1'b0;
   bit hold_off_done = 1'b0;

   rgb_to_hsv_8bit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   hsv_checker hsv_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hue         (rsp_hue),
      .rsp_saturation  (rsp_saturation),
      .rsp_brightness  (rsp_brightness),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always #6 clock = ~clock;

   // Offer one pixel from a falling edge and hold it until transferred;
   // close the burst with a random gap when it runs out
   task automatic send_pixel(input chan_type r, input chan_type g, input chan_type b);
      int gap;
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
      if (pixels_sent == HOLD_AT) hold_off_go = 1'b1;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   function automatic chan_type corner_value();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         3: return 8'd255;
         4: return 8'h55;
         default: return 8'hAA;
      endcase
   endfunction

   // Stimulus
   initial begin
      chan_type r, g, b, v, o;
      int directed_count;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // black, gray and white
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd255, 8'd255);
      // pure primaries
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      // tied maxima: red beats green and blue, green beats blue
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd7,   8'd7,   8'd3);
      // negative red-sector hue wraps
      send_pixel(8'd255, 8'd0,   8'd128);
      send_pixel(8'd1,   8'd0,   8'd1);
      send_pixel(8'd200, 8'd10,  8'd199);
      // smallest non-zero pixels and full saturation
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      // sector interiors and bit patterns
      send_pixel(8'd200, 8'd100, 8'd150);
      send_pixel(8'd10,  8'd20,  8'd30);
      send_pixel(8'd30,  8'd200, 8'd5);
      send_pixel(8'd170, 8'd85,  8'd85);
      send_pixel(8'd85,  8'd170, 8'd170);
      send_pixel(8'd254, 8'd255, 8'd253);
      directed_count = pixels_sent;

      // random mix
      repeat (RANDOM_PIXELS) begin
         case ($urandom_range(9))
            5: begin
               v = chan_type'($urandom_range(255));
               r = v; g = v; b = v;
            end
            6: begin
               v = chan_type'($urandom_range(255));
               o = chan_type'($urandom_range(v));
               case ($urandom_range(2))
                  0: begin r = v; g = v; b = o; end
                  1: begin r = o; g = v; b = v; end
                  default: begin r = v; g = o; b = v; end
               endcase
            end
            7: begin
               v = chan_type'($urandom_range(255));
               r = v ^ chan_type'($urandom_range(3));
               g = v ^ chan_type'($urandom_range(3));
               b = v ^ chan_type'($urandom_range(3));
            end
            8: begin
               r = corner_value();
               g = corner_value();
               b = corner_value();
            end
            9: begin
               r = chan_type'($urandom_range(3));
               g = chan_type'($urandom_range(3));
               b = chan_type'($urandom_range(3));
            end
            default: begin
               r = chan_type'($urandom_range(255));
               g = chan_type'($urandom_range(255));
               b = chan_type'($urandom_range(255));
            end
         endcase
         send_pixel(r, g, b);
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline depth for any stray result
      while (outstanding != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("Converted %0d pixels (%0d directed) and compared %0d results;",
               pixels_sent, directed_count, results_checked);
      $display("covered black, gray, tied-maximum, wrapped-hue and back-pressure cases.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Result side: stall on random modes, with one long hold-off
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(3);
               mode_left = $urandom_range(20, 100);
            end else begin
               mode_left--;
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(99) < 50);
               2: rsp_ready <= ($urandom_range(99) < 85);
               default: rsp_ready <= ($urandom_range(99) < 20);
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   idle_cycles, outstanding);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule

FILE: filelist.f
rtl/rhsv_pkg.sv
rtl/rgb_to_hsv_8bit.sv
tb/hsv_checker.sv
tb/tb.sv
